[src/rotm_pkg.sv]
// Shared types and constants of the rotation matrix generator.
`default_nettype none

package rotm_pkg;

    localparam int XW      = 33;   // CORDIC x/y datapath, LSB 2^-30
    localparam int ZW      = 28;   // CORDIC residual angle, LSB 2^-24 rad
    localparam int QW      = 16;   // Q1.14 result entries
    localparam int AW      = 16;   // Q3.13 input angle
    localparam int TBL_LEN = 24;

    localparam logic signed [AW-1:0] ANG_MAX  = 16'sd25736;
    localparam logic signed [ZW-1:0] PI_Z     = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353589;
    localparam logic signed [XW-1:0] GAIN_X   = 33'sd652032874;
    localparam logic signed [QW-1:0] ONE_Q14  = 16'sd16384;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_I = 2'd3;

    // atan(2^-i) in units of 2^-24 rad, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_TBL [TBL_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fold;
        logic [1:0]           axis;
    } rotm_cord_t;

    typedef struct packed {
        logic signed [QW-1:0] c;
        logic signed [QW-1:0] s;
        logic [1:0]           axis;
    } rotm_cs_t;

endpackage

`default_nettype wire

[src/axis_rotation_matrix.sv]
// Top level: elementary 3D rotation matrix from axis code and angle.
`default_nettype none

// Channel  | Direction | tdata                               | tuser
// ---------+-----------+-------------------------------------+-----------
// s_axis   | in        | [15:0] angle, Q3.13 rad             | [1:0] axis
// m_axis   | out       | 9 x 16 bit Q1.14 entries, row-major | none
//
// One request is taken per cycle while m_axis is not stalling; each
// request yields one matrix. The path registers the angle fold, one
// CORDIC micro-rotation per stage, the rounding, and the output register.
// Reset clears only the valid bits; the data registers are not reset.
// Every stage holds its contents under back-pressure and empty stages
// keep filling, so a stall drops and repeats nothing.

module axis_rotation_matrix #(
    parameter int SINCOS_STAGES = 15
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [15:0] angle
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] axis
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] row0_col0, [31:16] row0_col1, [47:32] row0_col2,
    // [63:48] row1_col0, [79:64] row1_col1, [95:80] row1_col2,
    // [111:96] row2_col0, [127:112] row2_col1, [143:128] row2_col2
    output logic [143:0]      m_axis_tdata
);
    import rotm_pkg::*;

    logic     cs_valid;
    logic     cs_ready;
    rotm_cs_t cs;

    rotm_sincos #(
        .SINCOS_STAGES(SINCOS_STAGES)
    ) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_axis   (s_axis_tuser),
        .in_angle  (s_axis_tdata),
        .out_valid (cs_valid),
        .out_ready (cs_ready),
        .out_cs    (cs)
    );

    logic               m_valid_reg;
    logic [143:0]       m_data_reg;
    logic signed [QW-1:0] mat [9];
    logic signed [QW-1:0] ns;

    // Advance the output register when it is empty or being drained.
    assign cs_ready      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Place cosine and sine into the matrix of the selected axis.
    always_comb begin
        ns = -cs.s;
        for (int j = 0; j < 9; j++) mat[j] = '0;
        unique case (cs.axis)
            AXIS_X: begin
                mat[0] = ONE_Q14; mat[4] = cs.c; mat[5] = ns;
                mat[7] = cs.s;    mat[8] = cs.c;
            end
            AXIS_Y: begin
                mat[0] = cs.c; mat[2] = cs.s; mat[4] = ONE_Q14;
                mat[6] = ns;   mat[8] = cs.c;
            end
            AXIS_Z: begin
                mat[0] = cs.c; mat[1] = ns; mat[3] = cs.s;
                mat[4] = cs.c; mat[8] = ONE_Q14;
            end
            AXIS_I: begin
                mat[0] = ONE_Q14; mat[4] = ONE_Q14; mat[8] = ONE_Q14;
            end
            default: begin
                mat[0] = ONE_Q14; mat[4] = ONE_Q14; mat[8] = ONE_Q14;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cs_ready) begin
            m_valid_reg <= cs_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cs_ready) begin
            for (int j = 0; j < 9; j++) m_data_reg[j*16 +: 16] <= mat[j];
        end
    end

endmodule

`default_nettype wire

[src/rotm_sincos.sv]
// Pipelined CORDIC sine/cosine unit with angle fold and Q1.14 rounding.
`default_nettype none

module rotm_sincos #(
    parameter int SINCOS_STAGES = 15
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_axis,
    input  wire logic signed [rotm_pkg::AW-1:0] in_angle,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rotm_pkg::rotm_cs_t               out_cs
);
    import rotm_pkg::*;

    localparam int N = (SINCOS_STAGES < TBL_LEN) ? SINCOS_STAGES : TBL_LEN;

    rotm_cord_t st_reg [0:N];
    rotm_cs_t   cs_reg;
    logic       vld_reg [0:N+1];
    logic       rdy [0:N+2];

    // A stage takes new data when it is empty or its successor moves.
    assign rdy[N+2] = out_ready;
    genvar k;
    generate
        for (k = 0; k <= N + 1; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[N+1];
    assign out_cs    = cs_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= N + 1; j++) vld_reg[j] <= 1'b0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            for (int j = 1; j <= N + 1; j++) begin
                if (rdy[j]) vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    // Prep: saturate, scale to internal angle, fold into +/- pi/2
    logic signed [AW-1:0] ang_sat;
    logic signed [ZW-1:0] z_raw;
    rotm_cord_t           prep_next;

    always_comb begin
        if (in_angle > ANG_MAX)       ang_sat = ANG_MAX;
        else if (in_angle < -ANG_MAX) ang_sat = -ANG_MAX;
        else                          ang_sat = in_angle;
        z_raw = {{(ZW-AW-11){ang_sat[AW-1]}}, ang_sat, 11'b0};
        prep_next.x    = GAIN_X;
        prep_next.y    = '0;
        prep_next.axis = in_axis;
        if (z_raw > HALF_PI_Z) begin
            prep_next.z    = z_raw - PI_Z;
            prep_next.fold = 1'b1;
        end else if (z_raw < -HALF_PI_Z) begin
            prep_next.z    = z_raw + PI_Z;
            prep_next.fold = 1'b1;
        end else begin
            prep_next.z    = z_raw;
            prep_next.fold = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) st_reg[0] <= prep_next;
    end

    // One micro-rotation per stage
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            rotm_cord_t stage_next;
            always_comb begin
                stage_next = st_reg[g];
                if (!st_reg[g].z[ZW-1]) begin
                    stage_next.x = st_reg[g].x - (st_reg[g].y >>> g);
                    stage_next.y = st_reg[g].y + (st_reg[g].x >>> g);
                    stage_next.z = st_reg[g].z - ATAN_TBL[g];
                end else begin
                    stage_next.x = st_reg[g].x + (st_reg[g].y >>> g);
                    stage_next.y = st_reg[g].y - (st_reg[g].x >>> g);
                    stage_next.z = st_reg[g].z + ATAN_TBL[g];
                end
            end
            always_ff @(posedge aclk) begin
                if (rdy[g+1]) st_reg[g+1] <= stage_next;
            end
        end
    endgenerate

    // Post: undo fold, round half up to Q1.14, saturate
    function automatic logic signed [QW-1:0] to_q14(input logic signed [XW-1:0] v,
                                                    input logic fold);
        logic signed [XW:0]   ve;
        logic signed [XW:0]   rs;
        logic signed [XW-16:0] r;
        begin
            ve = fold ? -{v[XW-1], v} : {v[XW-1], v};
            rs = (ve + (XW+1)'(32768)) >>> 16;
            r  = rs[XW-16:0];
            if (r > (XW-15)'(signed'(ONE_Q14)))       to_q14 = ONE_Q14;
            else if (r < -(XW-15)'(signed'(ONE_Q14))) to_q14 = -ONE_Q14;
            else                                      to_q14 = r[QW-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy[N+1]) begin
            cs_reg.c    <= to_q14(st_reg[N].x, st_reg[N].fold);
            cs_reg.s    <= to_q14(st_reg[N].y, st_reg[N].fold);
            cs_reg.axis <= st_reg[N].axis;
        end
    end

endmodule

`default_nettype wire
